[sv/trilinear_table_interpolator_defines.svh]
// Assertion helpers for the table interpolator.
`ifndef TRILINEAR_TABLE_INTERPOLATOR_DEFINES_SVH
`define TRILINEAR_TABLE_INTERPOLATOR_DEFINES_SVH
// Assert that an antecedent implies a consequent on the next edge.
`define TTI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("label failed");
// Assert that a condition holds on every edge out of reset.
`define TTI_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("label failed");
`endif

[sv/tti_pkg.sv]
package tti_pkg;
  localparam int unsigned CMD_LOOKUP  = 0;
  localparam int unsigned CMD_WR_MAP  = 1;
  localparam int unsigned CMD_WR_X    = 2;
  localparam int unsigned CMD_WR_Y    = 3;
  localparam int unsigned CMD_WR_Z    = 4;
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_CLAMP = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] query_x;
    logic [15:0] query_y;
    logic [15:0] query_z;
    logic [3:0]  slot_x;
    logic [3:0]  slot_y;
    logic [3:0]  slot_z;
    logic [15:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] result_value;
    logic [1:0]  status;
  } out_item_t;
endpackage

[sv/tti_ram.sv]
module tti_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[sv/tti_div.sv]
// Restoring divider, one quotient bit per cycle.
module tti_div #(
  parameter int NBITS = 80,
  parameter int DBITS = 48
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [NBITS-1:0] num,
  input  logic [DBITS-1:0] den,
  output logic             done,
  output logic [NBITS-1:0] quo
);
  localparam int CW = $clog2(NBITS + 1);
  logic [CW-1:0]    cnt;
  logic             run;
  logic [DBITS:0]   rem;
  logic [DBITS:0]   trial;
  logic [DBITS-1:0] dreg;

  assign trial = {rem[DBITS-1:0], quo[NBITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run  <= 1'b1;
        cnt  <= CW'(NBITS);
        quo  <= num;
        rem  <= '0;
        dreg <= den;
      end else if (run) begin
        // shift in one numerator bit, subtract if it fits
        if (trial >= {1'b0, dreg}) begin
          rem <= trial - {1'b0, dreg};
          quo <= {quo[NBITS-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[NBITS-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[sv/trilinear_table_interpolator.sv]
// Writes and unknown commands: S_IDLE accepts, then S_DONE gives the result strobe.
// Lookup: per axis S_AXIS_END, S_SCAN_W, a breakpoint scan in S_SCAN, S_EDGE_LO,
// S_EDGE_HI and S_CORNER_W; then 8 corners through S_CORNER, S_MAC and S_VOL1, then
// S_VOL2 and a restoring divide. A zero-width interval skips corners and divide. One
// transaction at a time: busy is high until the result strobe, so no new item is taken before
// the last is done. The receiver cannot stall; result and status are valid with done, high
// for one cycle. Synchronous reset clears control and sets point counts to 16, not memories.
`include "trilinear_table_interpolator_defines.svh"
module trilinear_table_interpolator #(
  parameter int POINTS_X   = 16,
  parameter int POINTS_Y   = 16,
  parameter int POINTS_Z   = 16,
  parameter int VALUE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  tti_pkg::in_item_t  in_item,
  output logic               done,
  output tti_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [4:0]         cfg_data
);
  localparam int DEPTH = POINTS_X * POINTS_Y * POINTS_Z;
  localparam int AW    = $clog2(DEPTH);
  localparam int PMAX  = (POINTS_X > POINTS_Y) ?
                         ((POINTS_X > POINTS_Z) ? POINTS_X : POINTS_Z) :
                         ((POINTS_Y > POINTS_Z) ? POINTS_Y : POINTS_Z);
  localparam int IW    = $clog2(PMAX + 1);
  localparam int BW    = $clog2(PMAX);
  localparam logic [VALUE_BITS-1:0] VMASK = '1;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_W, S_EDGE_LO, S_EDGE_HI, S_AXIS_END,
    S_CORNER, S_CORNER_W, S_MAC, S_VOL1, S_VOL2, S_DIV, S_DONE
  } state_t;

  state_t state;
  tti_pkg::in_item_t item;
  logic [4:0] xreg, yreg, zreg;
  logic [IW-1:0] np [3];
  logic [1:0] axis;
  logic [IW-1:0] j;
  logic [15:0] q [3];
  logic [15:0] lo [3];
  logic [15:0] hi [3];
  logic [IW-1:0] seg [3];
  logic [15:0] blast;
  logic flag, bad;
  logic [2:0] corner;
  logic [79:0] sum;
  logic [47:0] vol;
  logic [47:0] wgt;
  logic [31:0] wxy;

  // point counts in use
  function automatic logic [IW-1:0] in_use(input logic [4:0] r, input int lim);
    logic [IW-1:0] res;
    if (r < 5'd2) res = IW'(2);
    else if (32'(r) > lim) res = IW'(lim);
    else res = IW'(r);
    return res;
  endfunction

  assign np[0] = in_use(xreg, POINTS_X);
  assign np[1] = in_use(yreg, POINTS_Y);
  assign np[2] = in_use(zreg, POINTS_Z);

  // breakpoint rams
  logic [BW-1:0] braddr;
  logic [15:0] bx_rd, by_rd, bz_rd, brd;
  logic wex, wey, wez;
  logic accept;
  assign accept = start && !busy;
  assign wex = accept && in_item.cmd == 3'(tti_pkg::CMD_WR_X) &&
               32'(in_item.slot_x) < POINTS_X;
  assign wey = accept && in_item.cmd == 3'(tti_pkg::CMD_WR_Y) &&
               32'(in_item.slot_y) < POINTS_Y;
  assign wez = accept && in_item.cmd == 3'(tti_pkg::CMD_WR_Z) &&
               32'(in_item.slot_z) < POINTS_Z;

  logic [15:0] wv;
  assign wv = in_item.write_value & 16'(VMASK);

  tti_ram #(.WIDTH(16), .DEPTH(POINTS_X)) u_bx (
    .clk, .we(wex), .waddr($clog2(POINTS_X)'(in_item.slot_x)), .wdata(wv),
    .raddr($clog2(POINTS_X)'(braddr)), .rdata(bx_rd));
  tti_ram #(.WIDTH(16), .DEPTH(POINTS_Y)) u_by (
    .clk, .we(wey), .waddr($clog2(POINTS_Y)'(in_item.slot_y)), .wdata(wv),
    .raddr($clog2(POINTS_Y)'(braddr)), .rdata(by_rd));
  tti_ram #(.WIDTH(16), .DEPTH(POINTS_Z)) u_bz (
    .clk, .we(wez), .waddr($clog2(POINTS_Z)'(in_item.slot_z)), .wdata(wv),
    .raddr($clog2(POINTS_Z)'(braddr)), .rdata(bz_rd));

  always_comb begin
    case (axis)
      2'd0:    brd = bx_rd;
      2'd1:    brd = by_rd;
      default: brd = bz_rd;
    endcase
  end

  // map ram
  logic mwe;
  logic [AW-1:0] maddr_w, maddr_r;
  logic [AW+1:0] waddr_full;
  assign waddr_full = (AW+2)'((32'(in_item.slot_z) * 32'(np[1]) +
                      32'(in_item.slot_y)) * 32'(np[0]) + 32'(in_item.slot_x));
  assign maddr_w = waddr_full[AW-1:0];
  assign mwe = accept && in_item.cmd == 3'(tti_pkg::CMD_WR_MAP) &&
               32'(in_item.slot_x) < 32'(np[0]) && 32'(in_item.slot_y) < 32'(np[1]) &&
               32'(in_item.slot_z) < 32'(np[2]);

  logic [IW-1:0] cx, cy, cz;
  logic [AW+1:0] raddr_full;
  assign cx = seg[0] + IW'(corner[2]);
  assign cy = seg[1] + IW'(corner[1]);
  assign cz = seg[2] + IW'(corner[0]);
  assign raddr_full = (AW+2)'((32'(cz) * 32'(np[1]) + 32'(cy)) * 32'(np[0]) +
                      32'(cx));
  assign maddr_r = raddr_full[AW-1:0];

  logic [VALUE_BITS-1:0] mrd;
  tti_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_map (
    .clk, .we(mwe), .waddr(maddr_w), .wdata(VALUE_BITS'(wv)),
    .raddr(maddr_r), .rdata(mrd));

  // scan address
  always_comb begin
    case (state)
      S_EDGE_LO: braddr = BW'(seg[axis]);
      S_EDGE_HI: braddr = BW'(seg[axis] + 1'b1);
      S_AXIS_END: braddr = BW'(np[axis] - 1'b1);
      default:   braddr = BW'(j);
    endcase
  end

  // weights of the current corner
  logic [15:0] wa, wb, wc;
  assign wa = corner[2] ? q[0] - lo[0] : hi[0] - q[0];
  assign wb = corner[1] ? q[1] - lo[1] : hi[1] - q[1];
  assign wc = corner[0] ? q[2] - lo[2] : hi[2] - q[2];

  // divider
  logic div_go, div_done;
  logic [79:0] quo;
  tti_div #(.NBITS(80), .DBITS(48)) u_div (
    .clk, .rst, .go(div_go), .num(sum), .den(vol), .done(div_done), .quo(quo));

  logic [15:0] qa;
  assign qa = q[axis];

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      busy   <= 1'b0;
      done   <= 1'b0;
      div_go <= 1'b0;
      xreg   <= 5'd16;
      yreg   <= 5'd16;
      zreg   <= 5'd16;
    end else begin
      done   <= 1'b0;
      div_go <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          2'd0:    xreg <= cfg_data;
          2'd1:    yreg <= cfg_data;
          2'd2:    zreg <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            item <= in_item;
            busy <= 1'b1;
            q[0] <= in_item.query_x;
            q[1] <= in_item.query_y;
            q[2] <= in_item.query_z;
            flag <= 1'b0;
            bad  <= 1'b0;
            axis <= 2'd0;
            j    <= '0;
            if (in_item.cmd == 3'(tti_pkg::CMD_LOOKUP)) begin
              state <= S_AXIS_END;
            end else begin
              state <= S_DONE;
            end
          end
        end
        // first fetch last breakpoint and first, then clamp
        S_AXIS_END: begin
          state <= S_SCAN_W;
          j     <= '0;
        end
        S_SCAN_W: begin
          blast <= brd;
          state <= S_SCAN;
          j     <= IW'(1);
        end
        S_SCAN: begin
          // j-1 is on the read port; first visit also fixes the clamp
          if (j == IW'(1)) begin
            if (qa < brd) begin
              q[axis] <= brd;
              flag    <= 1'b1;
            end else if (qa > blast) begin
              q[axis] <= blast;
              flag    <= 1'b1;
            end
            seg[axis] <= '0;
            if ((qa < brd ? brd : (qa > blast ? blast : qa)) >= brd) begin
              j <= j + 1'b1;
            end else begin
              state <= S_EDGE_LO;
            end
          end else begin
            // hold the last interval at the top breakpoint
            if (qa >= brd && j != np[axis]) begin
              seg[axis] <= j - 1'b1;
              j         <= j + 1'b1;
            end else begin
              state <= S_EDGE_LO;
            end
          end
        end
        S_EDGE_LO: begin
          if (seg[axis] > np[axis] - IW'(2)) seg[axis] <= np[axis] - IW'(2);
          state <= S_EDGE_HI;
        end
        S_EDGE_HI: begin
          lo[axis] <= brd;
          state    <= S_CORNER_W;
        end
        S_CORNER_W: begin
          hi[axis] <= brd;
          if (brd <= lo[axis]) begin
            bad <= 1'b1;
          end else if (qa < lo[axis]) begin
            q[axis] <= lo[axis];
          end else if (qa > brd) begin
            q[axis] <= brd;
          end
          if (axis == 2'd2) begin
            state  <= S_CORNER;
            corner <= 3'd0;
            sum    <= '0;
          end else begin
            axis  <= axis + 1'b1;
            state <= S_AXIS_END;
          end
        end
        S_CORNER: begin
          if (bad) begin
            state <= S_DONE;
          end else begin
            wxy   <= 32'(wa) * 32'(wb);
            state <= S_MAC;
          end
        end
        S_MAC: begin
          wgt   <= 48'(wxy) * 48'(wc);
          state <= S_VOL1;
        end
        S_VOL1: begin
          // ram data for this corner is valid now
          sum <= sum + 80'(mrd) * 80'(wgt);
          if (corner == 3'd7) begin
            wxy   <= 32'(hi[0] - lo[0]) * 32'(hi[1] - lo[1]);
            state <= S_VOL2;
          end else begin
            corner <= corner + 1'b1;
            state  <= S_CORNER;
          end
        end
        S_VOL2: begin
          vol    <= 48'(wxy) * 48'(hi[2] - lo[2]);
          div_go <= 1'b1;
          state  <= S_DIV;
        end
        S_DIV: begin
          if (div_done) state <= S_DONE;
        end
        S_DONE: begin
          done  <= 1'b1;
          busy  <= 1'b0;
          state <= S_IDLE;
          if (item.cmd != 3'(tti_pkg::CMD_LOOKUP)) begin
            out_item <= '{result_value: 16'd0, status: tti_pkg::ST_OK};
          end else if (bad) begin
            out_item <= '{result_value: 16'd0, status: tti_pkg::ST_BAD};
          end else begin
            out_item <= '{result_value: quo[15:0],
                          status: flag ? tti_pkg::ST_CLAMP : tti_pkg::ST_OK};
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TTI_ASSERT_NEXT(a_done_single_pulse, clk, rst, done, !done)
  `TTI_ASSERT_NEXT(a_accept_sets_busy, clk, rst, accept, busy)
  `TTI_ASSERT_ALWAYS(a_done_not_idle_busy, clk, rst, !(done && busy))
endmodule
